@@ rtl/tesp_pkg.sv @@
// Package for the tree entry stream parser: field widths, byte class codes,
// character constants and the packed input and result item types.
// No dependencies.
package tesp_pkg;

  localparam int DATA_W      = 8;
  localparam int CLASS_W     = 3;
  localparam int IDX_W       = 6;
  localparam int MODE_W      = 32;
  localparam int NAME_LEN_W  = 12;
  localparam int ENTRY_CNT_W = 16;
  localparam int ID_LEN_W    = 7;

  localparam int NAME_COUNT_BITS_DEF  = 12;
  localparam int ENTRY_COUNT_BITS_DEF = 16;

  localparam logic [ID_LEN_W-1:0] ID_LEN_RESET = 7'd20;
  localparam logic [ID_LEN_W-1:0] ID_LEN_MIN   = 7'd1;
  localparam logic [ID_LEN_W-1:0] ID_LEN_MAX   = 7'd64;

  localparam logic [DATA_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [DATA_W-1:0] CH_SEVEN = 8'h37;
  localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
  localparam logic [DATA_W-1:0] CH_NUL   = 8'h00;

  typedef logic [CLASS_W-1:0] byte_class_t;

  localparam byte_class_t CL_MODE  = 3'd0;
  localparam byte_class_t CL_SPACE = 3'd1;
  localparam byte_class_t CL_NAME  = 3'd2;
  localparam byte_class_t CL_TERM  = 3'd3;
  localparam byte_class_t CL_ID    = 3'd4;

  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              last_byte;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0]      byte_value;
    byte_class_t            byte_class;
    logic [IDX_W-1:0]       id_byte_index;
    logic                   entry_done;
    logic [MODE_W-1:0]      mode_value;
    logic [NAME_LEN_W-1:0]  name_length;
    logic [ENTRY_CNT_W-1:0] entry_count;
    logic                   parse_error;
    logic                   object_done;
    logic                   object_ok;
  } out_item_t;

endpackage

@@ rtl/tesp_in_reg.sv @@
// Input register stage: captures one input transfer and holds it until the
// parser core consumes it. Depends on tesp_pkg.
module tesp_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  tesp_pkg::in_item_t in_data,
  input  logic              consume,
  output logic              item_valid,
  output tesp_pkg::in_item_t item
);

  logic               valid_r;
  logic               valid_nxt;
  tesp_pkg::in_item_t item_r;

  assign in_ready   = !valid_r || consume;
  assign valid_nxt  = (in_valid && in_ready) || (valid_r && !consume);
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

endmodule

@@ rtl/tesp_core.sv @@
// Parser core: id length register, per-entry and per-object state, byte
// classification and result formation. Depends on tesp_pkg.
module tesp_core #(
  parameter int NAME_COUNT_BITS  = tesp_pkg::NAME_COUNT_BITS_DEF,
  parameter int ENTRY_COUNT_BITS = tesp_pkg::ENTRY_COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tesp_pkg::ID_LEN_W-1:0]     cfg_wdata,
  input  logic                              step,
  input  tesp_pkg::in_item_t                item,
  output tesp_pkg::out_item_t               result
);

  localparam logic [1:0] PH_MODE_START = 2'd0;
  localparam logic [1:0] PH_MODE       = 2'd1;
  localparam logic [1:0] PH_NAME       = 2'd2;
  localparam logic [1:0] PH_ID         = 2'd3;

  localparam logic [NAME_COUNT_BITS-1:0]  NAME_MAX  = '1;
  localparam logic [ENTRY_COUNT_BITS-1:0] ENTRY_MAX = '1;

  logic [tesp_pkg::ID_LEN_W-1:0]     id_len_r;
  logic [1:0]                        phase_r, phase_upd, phase_nxt;
  logic [tesp_pkg::MODE_W-1:0]       mode_r, mode_upd, mode_nxt;
  logic [NAME_COUNT_BITS-1:0]        name_r, name_upd, name_nxt;
  logic [tesp_pkg::IDX_W-1:0]        id_r, id_upd, id_nxt;
  logic [ENTRY_COUNT_BITS-1:0]       ent_r, ent_upd, ent_nxt;
  logic                              err_r, err_upd, err_nxt;

  logic [tesp_pkg::ID_LEN_W-1:0]     len_eff;
  logic [tesp_pkg::DATA_W-1:0]       b;
  logic                              last;
  logic                              is_octal;
  logic                              done;
  tesp_pkg::byte_class_t             cls;
  logic [tesp_pkg::IDX_W-1:0]        idx;
  logic [tesp_pkg::NAME_LEN_W-1:0]   name_out;
  logic [tesp_pkg::ENTRY_CNT_W-1:0]  ent_out;

  assign b        = item.data_byte;
  assign last     = item.last_byte;
  assign is_octal = (b >= tesp_pkg::CH_ZERO) && (b <= tesp_pkg::CH_SEVEN);

  always_comb begin
    priority if (id_len_r < tesp_pkg::ID_LEN_MIN) begin
      len_eff = tesp_pkg::ID_LEN_MIN;
    end else if (id_len_r > tesp_pkg::ID_LEN_MAX) begin
      len_eff = tesp_pkg::ID_LEN_MAX;
    end else begin
      len_eff = id_len_r;
    end
  end

  always_comb begin
    phase_upd = phase_r;
    mode_upd  = mode_r;
    name_upd  = name_r;
    id_upd    = id_r;
    ent_upd   = ent_r;
    err_upd   = err_r;
    cls       = tesp_pkg::CL_MODE;
    idx       = '0;
    done      = 1'b0;
    unique case (phase_r)
      PH_MODE_START, PH_MODE: begin
        priority if (is_octal) begin
          cls       = tesp_pkg::CL_MODE;
          mode_upd  = {mode_r[tesp_pkg::MODE_W-4:0], b[2:0]};
          phase_upd = PH_MODE;
        end else if (b == tesp_pkg::CH_SPACE) begin
          cls = tesp_pkg::CL_SPACE;
          if (phase_r == PH_MODE_START) begin
            err_upd = 1'b1;
          end
          phase_upd = PH_NAME;
        end else if (b == tesp_pkg::CH_NUL) begin
          cls       = tesp_pkg::CL_TERM;
          err_upd   = 1'b1;
          id_upd    = '0;
          phase_upd = PH_ID;
        end else begin
          cls     = tesp_pkg::CL_MODE;
          err_upd = 1'b1;
        end
      end
      PH_NAME: begin
        if (b == tesp_pkg::CH_NUL) begin
          cls       = tesp_pkg::CL_TERM;
          id_upd    = '0;
          phase_upd = PH_ID;
        end else begin
          cls = tesp_pkg::CL_NAME;
          if (name_r != NAME_MAX) begin
            name_upd = name_r + 1'b1;
          end
        end
      end
      PH_ID: begin
        cls = tesp_pkg::CL_ID;
        idx = id_r;
        if (({1'b0, id_r} + 1'b1) >= len_eff) begin
          done = 1'b1;
          if (ent_r != ENTRY_MAX) begin
            ent_upd = ent_r + 1'b1;
          end
        end else begin
          id_upd = id_r + 1'b1;
        end
      end
    endcase
    if (last && !done) begin
      err_upd = 1'b1;
    end
  end

  generate
    if (NAME_COUNT_BITS >= tesp_pkg::NAME_LEN_W) begin : g_name_trunc
      assign name_out = name_upd[tesp_pkg::NAME_LEN_W-1:0];
    end else begin : g_name_ext
      assign name_out = {{(tesp_pkg::NAME_LEN_W-NAME_COUNT_BITS){1'b0}}, name_upd};
    end
    if (ENTRY_COUNT_BITS >= tesp_pkg::ENTRY_CNT_W) begin : g_ent_trunc
      assign ent_out = ent_upd[tesp_pkg::ENTRY_CNT_W-1:0];
    end else begin : g_ent_ext
      assign ent_out = {{(tesp_pkg::ENTRY_CNT_W-ENTRY_COUNT_BITS){1'b0}}, ent_upd};
    end
  endgenerate

  always_comb begin
    result.byte_value    = b;
    result.byte_class    = cls;
    result.id_byte_index = idx;
    result.entry_done    = done;
    result.mode_value    = mode_upd;
    result.name_length   = name_out;
    result.entry_count   = ent_out;
    result.parse_error   = err_upd;
    result.object_done   = last;
    result.object_ok     = last && done && !err_upd;
  end

  always_comb begin
    phase_nxt = phase_upd;
    mode_nxt  = mode_upd;
    name_nxt  = name_upd;
    id_nxt    = id_upd;
    ent_nxt   = ent_upd;
    err_nxt   = err_upd;
    if (last || done) begin
      phase_nxt = PH_MODE_START;
      mode_nxt  = '0;
      name_nxt  = '0;
      id_nxt    = '0;
    end
    if (last) begin
      ent_nxt = '0;
      err_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_len_r <= tesp_pkg::ID_LEN_RESET;
    end else if (cfg_we) begin
      id_len_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MODE_START;
      mode_r  <= '0;
      name_r  <= '0;
      id_r    <= '0;
      ent_r   <= '0;
      err_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      mode_r  <= mode_nxt;
      name_r  <= name_nxt;
      id_r    <= id_nxt;
      ent_r   <= ent_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

@@ rtl/tesp_out_reg.sv @@
// Result register stage: holds one result item until the consumer takes it.
// Depends on tesp_pkg.
module tesp_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  tesp_pkg::out_item_t result,
  output logic                out_valid,
  input  logic                out_ready,
  output tesp_pkg::out_item_t out_data
);

  logic                valid_r;
  logic                valid_nxt;
  tesp_pkg::out_item_t data_r;

  assign valid_nxt = load || (valid_r && !out_ready);
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

@@ rtl/tree_entry_stream_parser_top.sv @@
// Tree entry stream parser, top level: input register, parser core and
// result register. Depends on tesp_pkg, tesp_in_reg, tesp_core, tesp_out_reg.
//
// Takes one byte of a tree object body per clock while the result side does
// not stall, and returns one classified result per byte, in order. A byte
// passes the input register and the result register, in that order; the
// parser state updates once per byte, which sets a sustained rate of one
// byte per clock while out_ready stays high. The id length register is written
// through cfg_we and cfg_wdata and takes effect at once; write it only while
// no byte is in flight. There is no clearing pass after reset.
module tree_entry_stream_parser_top #(
  parameter int NAME_COUNT_BITS  = tesp_pkg::NAME_COUNT_BITS_DEF,
  parameter int ENTRY_COUNT_BITS = tesp_pkg::ENTRY_COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  tesp_pkg::in_item_t            in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output tesp_pkg::out_item_t           out_data,
  input  logic                          cfg_we,
  input  logic [tesp_pkg::ID_LEN_W-1:0] cfg_wdata
);

  logic                item_valid;
  tesp_pkg::in_item_t  item;
  tesp_pkg::out_item_t result;
  logic                step;

  // a held byte advances when the result register is free or draining
  assign step = item_valid && (!out_valid || out_ready);

  tesp_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .consume    (step),
    .item_valid (item_valid),
    .item       (item)
  );

  tesp_core #(
    .NAME_COUNT_BITS  (NAME_COUNT_BITS),
    .ENTRY_COUNT_BITS (ENTRY_COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .item      (item),
    .result    (result)
  );

  tesp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .result    (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ rtl/tesp_checker.sv @@
// Port-level checker for the tree entry stream parser, bound to the top level.
// Depends on tesp_pkg and tree_entry_stream_parser_top.
module tesp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_ready,
  input tesp_pkg::out_item_t out_data
);

  // stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_ok_implies: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.object_ok |->
      out_data.object_done && out_data.entry_done && !out_data.parse_error)
    else $error("object_ok without clean end");

  a_done_is_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.entry_done |-> out_data.byte_class == tesp_pkg::CL_ID)
    else $error("entry_done on non-id byte");

  a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_class != tesp_pkg::CL_ID |->
      out_data.id_byte_index == '0)
    else $error("id index set outside id");

endmodule

bind tree_entry_stream_parser_top tesp_checker u_tesp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

@@ test/tb_tree_entry_stream_parser_top.sv @@
// Testbench for tree_entry_stream_parser_top: drives tree object bytes and checks
// every classified result against a cycle-free model of the parser.
// Depends on tesp_pkg and tree_entry_stream_parser_top.
`timescale 1ns / 1ps

import tesp_pkg::*;

class tree_parse_scoreboard;
  typedef enum logic [1:0] {PH_MODE_START, PH_MODE, PH_NAME, PH_ID} parse_phase_t;

  logic [ID_LEN_W-1:0]    id_len_reg;
  parse_phase_t           phase;
  logic [MODE_W-1:0]      mode_acc;
  logic [NAME_LEN_W-1:0]  name_cnt;
  int                     id_cnt;
  logic [ENTRY_CNT_W-1:0] entry_cnt;
  bit                     err_seen;
  out_item_t              expected_q[$];
  int n_bytes, n_results, n_objects, n_ok, n_entries, n_fail;

  function new();
    id_len_reg = ID_LEN_RESET;
    clear_object();
  endfunction

  function void clear_entry();
    phase    = PH_MODE_START;
    mode_acc = '0;
    name_cnt = '0;
    id_cnt   = 0;
  endfunction

  function void clear_object();
    clear_entry();
    entry_cnt = '0;
    err_seen  = 1'b0;
  endfunction

  function void set_id_length(logic [ID_LEN_W-1:0] v);
    id_len_reg = v;
  endfunction

  // Works out the result of one accepted byte and queues it.
  function void note_byte(in_item_t it);
    out_item_t   exp;
    int          span;
    logic [7:0]  b;
    bit          done;
    b    = it.data_byte;
    done = 1'b0;
    exp  = '0;
    span = (id_len_reg < ID_LEN_MIN) ? 1 : (id_len_reg > ID_LEN_MAX) ? 64 : int'(id_len_reg);
    exp.byte_value = b;
    exp.byte_class = CL_MODE;
    case (phase)
      PH_MODE_START, PH_MODE: begin
        if (b >= CH_ZERO && b <= CH_SEVEN) begin
          mode_acc = {mode_acc[MODE_W-4:0], b[2:0]};
          phase    = PH_MODE;
        end else if (b == CH_SPACE) begin
          exp.byte_class = CL_SPACE;
          if (phase == PH_MODE_START) err_seen = 1'b1;
          phase = PH_NAME;
        end else if (b == CH_NUL) begin
          exp.byte_class = CL_TERM;
          err_seen = 1'b1;
          id_cnt   = 0;
          phase    = PH_ID;
        end else begin
          err_seen = 1'b1;
        end
      end
      PH_NAME: begin
        if (b == CH_NUL) begin
          exp.byte_class = CL_TERM;
          id_cnt = 0;
          phase  = PH_ID;
        end else begin
          exp.byte_class = CL_NAME;
          if (name_cnt != '1) name_cnt++;
        end
      end
      default: begin
        exp.byte_class    = CL_ID;
        exp.id_byte_index = IDX_W'(id_cnt);
        if (id_cnt + 1 >= span) begin
          done = 1'b1;
          if (entry_cnt != '1) entry_cnt++;
        end else begin
          id_cnt = (id_cnt + 1) % 64;
        end
      end
    endcase
    if (it.last_byte && !done) err_seen = 1'b1;
    exp.entry_done  = done;
    exp.mode_value  = mode_acc;
    exp.name_length = name_cnt;
    exp.entry_count = entry_cnt;
    exp.parse_error = err_seen;
    exp.object_done = it.last_byte;
    exp.object_ok   = it.last_byte && done && !err_seen;
    expected_q.push_back(exp);
    n_bytes++;
    if (done) n_entries++;
    if (it.last_byte) begin
      n_objects++;
      if (exp.object_ok) n_ok++;
      clear_object();
    end else if (done) begin
      clear_entry();
    end
  endfunction

  function void compare_field(string field, logic [MODE_W-1:0] want, logic [MODE_W-1:0] actual);
    if (want !== actual) begin
      if (n_fail < 50) $error("%s: expected 0x%0h, actual 0x%0h", field, want, actual);
      n_fail++;
    end
  endfunction

  function void check_result(out_item_t actual);
    out_item_t want;
    if (expected_q.size() == 0) begin
      if (n_fail < 50) $error("result with no byte outstanding: 0x%0h", actual);
      n_fail++;
      return;
    end
    want = expected_q.pop_front();
    n_results++;
    compare_field("byte_value", want.byte_value, actual.byte_value);
    compare_field("byte_class", want.byte_class, actual.byte_class);
    compare_field("id_byte_index", want.id_byte_index, actual.id_byte_index);
    compare_field("entry_done", want.entry_done, actual.entry_done);
    compare_field("mode_value", want.mode_value, actual.mode_value);
    compare_field("name_length", want.name_length, actual.name_length);
    compare_field("entry_count", want.entry_count, actual.entry_count);
    compare_field("parse_error", want.parse_error, actual.parse_error);
    compare_field("object_done", want.object_done, actual.object_done);
    compare_field("object_ok", want.object_ok, actual.object_ok);
  endfunction

  function void finish_check();
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      n_fail++;
    end
  endfunction
endclass

module tb_tree_entry_stream_parser_top;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 60;
  localparam int DRAIN_SLACK = 4;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_item_t            in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_we = 1'b0;
  logic [ID_LEN_W-1:0] cfg_wdata = '0;

  tree_parse_scoreboard sb;
  logic [7:0] obj_q[$];
  int  bytes_sent;
  int  settings_written;
  int  cycle_count;
  int  hold_asked;
  int  hold_served;
  int  hold_left;
  bit  idle_en = 1'b1;
  logic [ID_LEN_W-1:0] cur_id_len = ID_LEN_RESET;

  tree_entry_stream_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_byte(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
    end
  end

  // receiver: random stalls plus a single long hold-off
  always @(posedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served = hold_asked;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !idle_en || ($urandom_range(99) >= 14);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    in_item_t t;
    t.data_byte = b;
    t.last_byte = last;
    if (idle_en && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_object();
    for (int i = 0; i < obj_q.size(); i++) send_byte(obj_q[i], i == obj_q.size() - 1);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.n_results < bytes_sent) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
  endtask

  task automatic write_id_length(input logic [ID_LEN_W-1:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_id_length(v);
    cur_id_len = v;
    settings_written++;
  endtask

  function automatic logic [7:0] bad_mode_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(1, 255));
    while ((c >= CH_ZERO && c <= CH_SEVEN) || c == CH_SPACE);
    return c;
  endfunction

  // Mostly well-formed entries; the rest are noise, bad digits, empty mode
  // or missing separator.
  task automatic push_entry(input int span);
    int kind;
    int n;
    kind = $urandom_range(99);
    if (kind >= 93) begin
      repeat ($urandom_range(1, 5)) obj_q.push_back(8'($urandom_range(255)));
      return;
    end
    n = ($urandom_range(9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 6);
    if (kind >= 85 && kind < 89) n = 0;
    repeat (n) obj_q.push_back(CH_ZERO + 8'($urandom_range(7)));
    if (kind >= 80 && kind < 85) begin
      obj_q.push_back(bad_mode_byte());
      obj_q.push_back(CH_ZERO + 8'($urandom_range(7)));
    end
    if (!(kind >= 89 && kind < 93)) begin
      obj_q.push_back(CH_SPACE);
      repeat ($urandom_range(0, 6))
        obj_q.push_back(($urandom_range(6) == 0) ? CH_SPACE : 8'($urandom_range(1, 255)));
    end
    obj_q.push_back(CH_NUL);
    repeat (span) obj_q.push_back(8'($urandom_range(255)));
  endtask

  task automatic build_object();
    int span;
    int cut;
    span = (cur_id_len < ID_LEN_MIN) ? 1 : (cur_id_len > ID_LEN_MAX) ? 64 : int'(cur_id_len);
    obj_q.delete();
    repeat ($urandom_range(1, 4)) push_entry(span);
    if ($urandom_range(99) < 12 && obj_q.size() > 1) begin
      cut = $urandom_range(1, obj_q.size() - 1);
      obj_q = obj_q[0:cut-1];
    end
  endtask

  initial begin
    int plan[6];
    int phase_items;
    int objs;
    plan = '{64, 0, 127, 2, 1, 20};
    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset id length, then the corner cases with a one-byte id
    obj_q = {8'h31, 8'h30, 8'h30, 8'h36, 8'h34, 8'h34, CH_SPACE, 8'h61, CH_NUL, 8'h00, 8'hFF};
    repeat (18) obj_q.push_back(8'($urandom_range(255)));
    send_object();
    write_id_length(ID_LEN_MIN);
    obj_q = {CH_ZERO, CH_SEVEN, CH_SPACE, 8'hFF, CH_SPACE, 8'h01, CH_NUL, 8'hA5};
    send_object();
    obj_q = {8'h38, 8'h33, CH_SPACE, CH_NUL, 8'h5A};
    send_object();
    obj_q = {CH_SPACE, 8'h61, CH_NUL, 8'h00};
    send_object();
    obj_q = {8'h35, CH_NUL, 8'hFF};
    send_object();
    obj_q = {8'h31, CH_SPACE, 8'h78};
    send_object();
    obj_q = {CH_ZERO};
    send_object();

    for (int p = 0; p < 10; p++) begin
      write_id_length((p < 6) ? ID_LEN_W'(plan[p]) : ID_LEN_W'($urandom_range(1, 10)));
      idle_en = (p != 2);
      if (p == 3) hold_asked++;
      phase_items = 0;
      objs = 0;
      while (phase_items < 200) begin
        build_object();
        phase_items += obj_q.size();
        send_object();
        objs++;
        if (p == 6 && objs == 1) drain_results();
      end
    end
    idle_en = 1'b1;

    drain_results();
    sb.finish_check();
    $display("Covered %0d bytes in %0d objects (%0d well formed), %0d entries, %0d id lengths",
             sb.n_bytes, sb.n_objects, sb.n_ok, sb.n_entries, settings_written);
    $display("Exercised mode wrap, malformed and cut-off entries, out-of-range id lengths,");
    $display("a long result hold-off and full drain pauses");
    if (sb.n_fail == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

@@ tree_entry_stream_parser_top.f @@
rtl/tesp_pkg.sv
rtl/tesp_in_reg.sv
rtl/tesp_core.sv
rtl/tesp_out_reg.sv
rtl/tree_entry_stream_parser_top.sv
rtl/tesp_checker.sv
test/tb_tree_entry_stream_parser_top.sv
